/* rtl/pad_and_keyboard_to_hid_report_defines.svh */
// Assertion macros for the poll-to-report converter.
`ifndef PAD_AND_KEYBOARD_TO_HID_REPORT_DEFINES_SVH
`define PAD_AND_KEYBOARD_TO_HID_REPORT_DEFINES_SVH
// Immediate implication checked at every clock edge outside reset.
`define PKH_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define PKH_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* rtl/pkhr_pkg.sv */
// ----------------------------------------------------------------------------
// pkhr_pkg
// Types, constants and lookup functions shared by the converter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pkhr_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int SCAN_W = 4;

   typedef enum logic [1:0] {
      SRC_KBD_A = 2'd0,
      SRC_KBD_B = 2'd1,
      SRC_PAD_A = 2'd2,
      SRC_PAD_B = 2'd3
   } src_type;

   typedef struct packed {
      logic [15:0] pad_buttons;
      logic [7:0]  stick_y;
      logic [7:0]  stick_x;
      logic [7:0]  kbd_flags;
      logic [15:0] code_c;
      logic [15:0] code_b;
      logic [15:0] code_a;
      src_type     req_type;
   } req_type_s_type;

   typedef logic [KEY_SLOTS-1:0][7:0] slots_type;

   typedef struct packed {
      logic       caps_led;
      logic       clear_last;
      logic       report_changed;
      logic [5:0][7:0] keys;
      logic [7:0] modifiers;
   } rsp_type;

   // One key event: either a modifier bit or a usage code, or nothing.
   typedef struct packed {
      logic       is_mod;
      logic [7:0] mod_bit;
      logic [7:0] usage;
   } key_ev_type;

   function automatic logic [7:0] kb_a_mod_bit(input logic [7:0] code);
      logic [7:0] r;
      case (code)
         8'h56: r = 8'h01;
         8'h54: r = 8'h02;
         8'h57: r = 8'h04;
         8'h58: r = 8'h08;
         8'h55: r = 8'h20;
         8'h5a: r = 8'h80;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] usage_mod_bit(input logic [7:0] u);
      logic [7:0] r;
      case (u)
         8'he0: r = 8'h01;
         8'he1: r = 8'h02;
         8'he2: r = 8'h04;
         8'he3: r = 8'h08;
         8'he5: r = 8'h20;
         8'he7: r = 8'h80;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Keyboard A codes in the range 3 up to 0x61.
   function automatic logic [7:0] kb_a_usage(input logic [7:0] code);
      logic [7:0] r;
      if (code >= 8'h10 && code < 8'h34) r = code - 8'h0c;
      else if (code >= 8'h40 && code < 8'h4c) r = code - 8'h06;
      else begin
         case (code)
            8'h06: r = 8'h4a; 8'h07: r = 8'h4d; 8'h08: r = 8'h4b;
            8'h09: r = 8'h4e; 8'h0a: r = 8'h47;
            8'h34: r = 8'h2d; 8'h35: r = 8'h2e; 8'h36: r = 8'h31;
            8'h37: r = 8'h55; 8'h38: r = 8'h2f; 8'h39: r = 8'h33;
            8'h3a: r = 8'h34; 8'h3b: r = 8'h30; 8'h3c: r = 8'h36;
            8'h3d: r = 8'h37; 8'h3e: r = 8'h38; 8'h3f: r = 8'h31;
            8'h4c: r = 8'h29; 8'h4d: r = 8'h49; 8'h4e: r = 8'h4c;
            8'h4f: r = 8'h35; 8'h50: r = 8'h2a; 8'h51: r = 8'h2b;
            8'h53: r = 8'h39; 8'h54: r = 8'he1; 8'h55: r = 8'he5;
            8'h56: r = 8'he0; 8'h57: r = 8'he2; 8'h58: r = 8'he3;
            8'h59: r = 8'h2c; 8'h5a: r = 8'he7; 8'h5b: r = 8'h65;
            8'h5c: r = 8'h50; 8'h5d: r = 8'h51; 8'h5e: r = 8'h52;
            8'h5f: r = 8'h4f; 8'h61: r = 8'h28;
            default: r = 8'h03;
         endcase
      end
      return r;
   endfunction

   function automatic key_ev_type kb_a_event(input logic [7:0] code);
      key_ev_type e;
      e.is_mod = 1'b0;
      e.mod_bit = 8'h00;
      e.usage = 8'h00;
      if (code >= 8'h03 && code < 8'h62) begin
         e.mod_bit = kb_a_mod_bit(code);
         e.is_mod = (e.mod_bit != 8'h00);
         if (!e.is_mod) e.usage = kb_a_usage(code);
      end
      return e;
   endfunction

   function automatic logic [7:0] kb_b_usage(input logic [15:0] code);
      logic [7:0] r;
      logic [7:0] hi;
      logic [7:0] lo;
      hi = code[15:8];
      lo = code[7:0];
      r = 8'h03;
      if (code == 16'h0000) r = 8'h00;
      else if (lo != 8'h00 && lo <= 8'h08 && hi >= 8'h02) begin
         case ({lo[3:0], hi})
            12'h102: r=8'h03; 12'h103: r=8'h03; 12'h104: r=8'h03; 12'h105: r=8'h1a;
            12'h106: r=8'h08; 12'h107: r=8'h15; 12'h108: r=8'h17; 12'h109: r=8'h1c;
            12'h10a: r=8'h3b; 12'h10b: r=8'h3a; 12'h10c: r=8'h14; 12'h10d: r=8'h2b;
            12'h10e: r=8'he1;
            12'h206: r=8'h2c; 12'h207: r=8'h38; 12'h208: r=8'h37; 12'h209: r=8'h36;
            12'h20a: r=8'h3f; 12'h20b: r=8'h40; 12'h20e: r=8'he7; 12'h210: r=8'he3;
            12'h302: r=8'h44; 12'h306: r=8'h34; 12'h307: r=8'h33; 12'h308: r=8'h0f;
            12'h309: r=8'h0e; 12'h30a: r=8'h41; 12'h30b: r=8'h42;
            12'h402: r=8'h52; 12'h405: r=8'h55; 12'h406: r=8'h13; 12'h407: r=8'h12;
            12'h408: r=8'h0c; 12'h409: r=8'h18; 12'h40a: r=8'h43; 12'h40c: r=8'h2f;
            12'h40d: r=8'h28; 12'h410: r=8'h31;
            12'h502: r=8'h50; 12'h503: r=8'h51; 12'h504: r=8'h4f; 12'h505: r=8'h1f;
            12'h506: r=8'h20; 12'h507: r=8'h21; 12'h508: r=8'h22; 12'h509: r=8'h23;
            12'h50a: r=8'h53; 12'h50b: r=8'h00; 12'h50c: r=8'h1e; 12'h50d: r=8'h35;
            12'h50f: r=8'h39; 12'h511: r=8'h31;
            12'h602: r=8'h4d; 12'h604: r=8'h30; 12'h605: r=8'h2d; 12'h606: r=8'h27;
            12'h607: r=8'h26; 12'h608: r=8'h25; 12'h609: r=8'h24; 12'h60b: r=8'h45;
            12'h60c: r=8'h2e; 12'h60d: r=8'h2a; 12'h60e: r=8'he5; 12'h610: r=8'h65;
            12'h702: r=8'h00; 12'h705: r=8'h07; 12'h706: r=8'h09; 12'h707: r=8'h0a;
            12'h708: r=8'h0b; 12'h709: r=8'h0d; 12'h70a: r=8'h3d; 12'h70b: r=8'h3e;
            12'h70c: r=8'h16; 12'h70d: r=8'h04; 12'h711: r=8'he0;
            12'h802: r=8'h00; 12'h805: r=8'h06; 12'h806: r=8'h19; 12'h807: r=8'h05;
            12'h808: r=8'h11; 12'h809: r=8'h10; 12'h80a: r=8'h29; 12'h80b: r=8'h3c;
            12'h80c: r=8'h1b; 12'h80d: r=8'h1d; 12'h810: r=8'he2;
            default: r = 8'h03;
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/pkhr_decode.sv */
// ----------------------------------------------------------------------------
// pkhr_decode
// Turns one poll into a list of key events (modifier bits or usage codes).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pkhr_decode (
   input  wire pkhr_pkg::req_type_s_type req,
   output pkhr_pkg::key_ev_type [pkhr_pkg::KEY_SLOTS:0] events,
   output logic caps_hits
);
   localparam int N = pkhr_pkg::KEY_SLOTS;

   logic [N-1:0][7:0] scan;
   logic [pkhr_pkg::SCAN_W-1:0] n;
   logic [7:0] sx;
   logic [7:0] sy;
   logic right, left, up, down, btn_a, btn_b, btn_x;
   logic [3:0][7:0] push_code;
   logic [7:0] u;
   logic caps_cnt;
   logic is_pad;

   always_comb begin
      scan = '0;
      n = '0;
      u = '0;
      caps_cnt = 1'b0;
      is_pad = req.req_type[1];
      if (req.req_type == pkhr_pkg::SRC_PAD_A) begin
         sx = req.stick_x ^ 8'h80;
         sy = req.stick_y ^ 8'h80;
         right = req.pad_buttons[1]; left = req.pad_buttons[0];
         up = req.pad_buttons[3]; down = req.pad_buttons[2];
         btn_a = req.pad_buttons[8]; btn_b = req.pad_buttons[9];
         btn_x = req.pad_buttons[10];
      end else begin
         sx = req.stick_x;
         sy = req.stick_y;
         right = req.pad_buttons[8]; left = req.pad_buttons[9];
         up = req.pad_buttons[11]; down = req.pad_buttons[10];
         btn_a = req.pad_buttons[15]; btn_b = req.pad_buttons[14];
         btn_x = req.pad_buttons[13];
      end
      push_code[0] = 8'h5f; push_code[1] = 8'h5c;
      push_code[2] = 8'h5e; push_code[3] = 8'h5d;
      // Stick beyond 64 each way, then the direction buttons.
      for (int i = 0; i < 8; i++) begin
         logic hit;
         case (i)
            0: hit = !sx[7] && sx > 8'd64;
            1: hit = sx[7] && sx < 8'hc0;
            2: hit = !sy[7] && sy > 8'd64;
            3: hit = sy[7] && sy < 8'hc0;
            4: hit = right;
            5: hit = left;
            6: hit = up;
            default: hit = down;
         endcase
         if (hit && n < pkhr_pkg::SCAN_W'(N)) begin
            scan[n[$clog2(N)-1:0]] = push_code[i % 4];
            n = n + 1'b1;
         end
      end
      if (n < pkhr_pkg::SCAN_W'(N)) begin
         if (btn_a || btn_b) begin
            scan[n[$clog2(N)-1:0]] = btn_a ? 8'h61 : 8'h4c;
            n = n + 1'b1;
         end
         if (btn_x && n < pkhr_pkg::SCAN_W'(N)) begin
            scan[n[$clog2(N)-1:0]] = 8'h22;
            n = n + 1'b1;
         end
      end

      events = '0;
      if (is_pad) begin
         for (int i = 0; i < N; i++) events[i+1] = pkhr_pkg::kb_a_event(scan[i]);
      end else if (req.req_type == pkhr_pkg::SRC_KBD_A) begin
         events[1] = pkhr_pkg::kb_a_event(req.code_a[7:0]);
         events[2] = pkhr_pkg::kb_a_event(req.code_b[7:0]);
         events[3] = pkhr_pkg::kb_a_event(req.code_c[7:0]);
      end else if (!req.kbd_flags[4]) begin
         if (req.kbd_flags[0]) events[0].usage = 8'h4a;
         for (int i = 0; i < 3; i++) begin
            case (i)
               0: u = pkhr_pkg::kb_b_usage(req.code_a);
               1: u = pkhr_pkg::kb_b_usage(req.code_b);
               default: u = pkhr_pkg::kb_b_usage(req.code_c);
            endcase
            if (u > 8'h03) begin
               if (u == 8'h39) caps_cnt = ~caps_cnt;
               events[i+1].mod_bit = pkhr_pkg::usage_mod_bit(u);
               events[i+1].is_mod = (events[i+1].mod_bit != 8'h00);
               if (!events[i+1].is_mod) events[i+1].usage = u;
            end
         end
      end
      caps_hits = caps_cnt;
   end
endmodule
`default_nettype wire

/* rtl/pkhr_place.sv */
// ----------------------------------------------------------------------------
// pkhr_place
// Places key events into report slots with deduplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pkhr_place (
   input  wire pkhr_pkg::key_ev_type [pkhr_pkg::KEY_SLOTS:0] events,
   output pkhr_pkg::slots_type slots,
   output logic [7:0] mods,
   output logic changed
);
   localparam int N = pkhr_pkg::KEY_SLOTS;

   always_comb begin
      slots = '0;
      mods = '0;
      changed = 1'b0;
      for (int e = 0; e <= N; e++) begin
         logic dup;
         logic placed;
         dup = 1'b0;
         placed = 1'b0;
         if (events[e].is_mod) begin
            if ((mods & events[e].mod_bit) == 8'h00) begin
               mods = mods | events[e].mod_bit;
               changed = 1'b1;
            end
         end else if (events[e].usage > 8'h03) begin
            for (int i = 0; i < N; i++)
               if (slots[i] == events[e].usage) dup = 1'b1;
            if (dup) changed = 1'b1;
            else begin
               for (int i = 0; i < N; i++) begin
                  if (!placed && slots[i] == 8'h00) begin
                     slots[i] = events[e].usage;
                     placed = 1'b1;
                  end
               end
               if (placed) changed = 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/pad_and_keyboard_to_hid_report.sv */
// Each accepted word is captured in the output register and offered on the rsp side from there.
// Throughput: one word per clock while the sink keeps taking words; the decode and slot placement run in one pass.
// The only stall is the single output register: it refills whenever the sink
// takes its word or it is empty. Synchronous active-high reset clears the
// output valid flag and the kept Caps Lock bit.
// ----------------------------------------------------------------------------
// pad_and_keyboard_to_hid_report
// Converts keyboard or pad polls to USB HID boot keyboard reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pad_and_keyboard_to_hid_report_defines.svh"
module pad_and_keyboard_to_hid_report (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: code_a[16], code_b[16], code_c[16], kbd_flags[8],
   // pad_buttons[16], stick_x[8], stick_y[8]
   input  wire  [87:0] req_tdata,
   // tuser: req_type[2]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata from bit 0: modifiers, key_slot_0..5, report_changed, clear_last,
   // caps_led, then zero fill
   output logic [63:0] rsp_tdata
);
   pkhr_pkg::req_type_s_type req;
   pkhr_pkg::key_ev_type [pkhr_pkg::KEY_SLOTS:0] events;
   pkhr_pkg::slots_type slots;
   logic [7:0] mods;
   logic changed;
   logic caps_hits;
   logic caps_ff, caps_in;
   logic valid_ff;
   logic [58:0] data_ff, data_in;
   logic take;

   // Fields are taken straight from the input word.
   always_comb begin
      req.req_type    = pkhr_pkg::src_type'(req_tuser);
      req.code_a      = req_tdata[15:0];
      req.code_b      = req_tdata[31:16];
      req.code_c      = req_tdata[47:32];
      req.kbd_flags   = req_tdata[55:48];
      req.pad_buttons = req_tdata[71:56];
      req.stick_x     = req_tdata[79:72];
      req.stick_y     = req_tdata[87:80];
   end

   pkhr_decode u_decode (.req(req), .events(events), .caps_hits(caps_hits));
   pkhr_place u_place (.events(events), .slots(slots), .mods(mods), .changed(changed));

   assign req_tready = !valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;

   // Caps Lock toggles once per Caps key in a keyboard B word.
   always_comb begin
      caps_in = caps_ff ^ (take && caps_hits);
      data_in = {caps_in, !changed && slots[0] == 8'h00, changed,
                 slots[5], slots[4], slots[3], slots[2], slots[1], slots[0], mods};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         caps_ff <= 1'b0;
      end else begin
         caps_ff <= caps_in;
         if (take) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
      if (take) data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {5'd0, data_ff};

   `PKH_ASSERT_NEXT(a_caps_idle, clock, reset, !take, caps_ff == $past(caps_ff))
   `PKH_ASSERT_IMP(a_clear_excl, clock, reset, rsp_tvalid, !(rsp_tdata[57] && rsp_tdata[56]))
   `PKH_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && rsp_tdata == $past(rsp_tdata))
endmodule
`default_nettype wire

/* tb/sv/pad_and_keyboard_to_hid_report_tb.sv */
// ----------------------------------------------------------------------------
// pad_and_keyboard_to_hid_report_tb
// Self-checking bench for the poll-to-report converter. Keyboard and pad polls
// are streamed in with random gaps, each report is predicted in the bench and
// compared field by field with the word the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pad_and_keyboard_to_hid_report_tb;

   // One poll as it travels on the request side.
   typedef struct {
      pkhr_pkg::src_type kind;
      logic [15:0] code_a;
      logic [15:0] code_b;
      logic [15:0] code_c;
      logic [7:0]  kbd_flags;
      logic [15:0] pad_buttons;
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
   } poll_type;

   // One expected HID report.
   typedef struct {
      logic [7:0]      mods;
      logic [5:0][7:0] keys;
      logic            changed;
      logic            clear_last;
      logic            caps;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [63:0] rsp_tdata;

   poll_type   pending_polls[$];
   report_type expected_reports[$];
   logic    caps_model;
   int      error_count = 0;
   bit      stim_done = 0;
   bit      quiet_send = 0;   // sender never idles while this is set
   bit      quiet_recv = 0;   // receiver never stalls while this is set
   bit      hold_go = 0;      // starts the long receiver hold-off
   bit      hold_on = 0;      // receiver is held off while this is set

   pad_and_keyboard_to_hid_report dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Lookup tables of the mapping, written out in row form.
   // ---------------------------------------------------------------------
   function automatic logic [7:0] row_b_usage(input logic [15:0] code);
      logic [7:0] hi;
      logic [7:0] lo;
      int idx;
      logic [7:0] r1[13] = '{8'h03,8'h03,8'h03,8'h1a,8'h08,8'h15,8'h17,8'h1c,
                             8'h3b,8'h3a,8'h14,8'h2b,8'he1};
      logic [7:0] r2[15] = '{8'h03,8'h03,8'h03,8'h03,8'h2c,8'h38,8'h37,8'h36,
                             8'h3f,8'h40,8'h03,8'h03,8'he7,8'h03,8'he3};
      logic [7:0] r3[10] = '{8'h44,8'h03,8'h03,8'h03,8'h34,8'h33,8'h0f,8'h0e,
                             8'h41,8'h42};
      logic [7:0] r4[15] = '{8'h52,8'h03,8'h03,8'h55,8'h13,8'h12,8'h0c,8'h18,
                             8'h43,8'h03,8'h2f,8'h28,8'h03,8'h03,8'h31};
      logic [7:0] r5[16] = '{8'h50,8'h51,8'h4f,8'h1f,8'h20,8'h21,8'h22,8'h23,
                             8'h53,8'h00,8'h1e,8'h35,8'h03,8'h39,8'h03,8'h31};
      logic [7:0] r6[15] = '{8'h4d,8'h03,8'h30,8'h2d,8'h27,8'h26,8'h25,8'h24,
                             8'h03,8'h45,8'h2e,8'h2a,8'he5,8'h03,8'h65};
      logic [7:0] r7[16] = '{8'h00,8'h03,8'h03,8'h07,8'h09,8'h0a,8'h0b,8'h0d,
                             8'h3d,8'h3e,8'h16,8'h04,8'h03,8'h03,8'h03,8'he0};
      logic [7:0] r8[15] = '{8'h00,8'h03,8'h03,8'h06,8'h19,8'h05,8'h11,8'h10,
                             8'h29,8'h3c,8'h1b,8'h1d,8'h03,8'h03,8'he2};
      hi = code[15:8];
      lo = code[7:0];
      if (code == 16'h0) return 8'h00;
      if (lo == 8'h0 || lo > 8'h8 || hi < 8'h2) return 8'h03;
      idx = hi - 2;
      case (lo)
         8'h1: return idx < 13 ? r1[idx] : 8'h03;
         8'h2: return idx < 15 ? r2[idx] : 8'h03;
         8'h3: return idx < 10 ? r3[idx] : 8'h03;
         8'h4: return idx < 15 ? r4[idx] : 8'h03;
         8'h5: return idx < 16 ? r5[idx] : 8'h03;
         8'h6: return idx < 15 ? r6[idx] : 8'h03;
         8'h7: return idx < 16 ? r7[idx] : 8'h03;
         default: return idx < 15 ? r8[idx] : 8'h03;
      endcase
   endfunction

   function automatic logic [7:0] code_a_to_usage(input logic [7:0] code);
      logic [7:0] low_t[16] = '{8'h00,8'h01,8'h02,8'h03,8'h03,8'h03,8'h4a,8'h4d,
                                8'h4b,8'h4e,8'h47,8'h03,8'h03,8'h03,8'h03,8'h03};
      logic [7:0] mid_t[12] = '{8'h2d,8'h2e,8'h31,8'h55,8'h2f,8'h33,8'h34,8'h30,
                                8'h36,8'h37,8'h38,8'h31};
      logic [7:0] high_t[22] = '{8'h29,8'h49,8'h4c,8'h35,8'h2a,8'h2b,8'h03,8'h39,
                                 8'he1,8'he5,8'he0,8'he2,8'he3,8'h2c,8'he7,8'h65,
                                 8'h50,8'h51,8'h52,8'h4f,8'h03,8'h28};
      if (code >= 8'h10 && code < 8'h34) return code - 8'h0c;
      if (code >= 8'h40 && code < 8'h4c) return code - 8'h06;
      if (code < 8'h10) return low_t[code];
      if (code < 8'h40) return mid_t[code - 8'h34];
      return high_t[(code - 8'h4c) % 22];
   endfunction

   function automatic logic [7:0] mod_of_code_a(input logic [7:0] code);
      case (code)
         8'h56: return 8'h01;
         8'h54: return 8'h02;
         8'h57: return 8'h04;
         8'h58: return 8'h08;
         8'h55: return 8'h20;
         8'h5a: return 8'h80;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] mod_of_usage(input logic [7:0] u);
      case (u)
         8'he0: return 8'h01;
         8'he1: return 8'h02;
         8'he2: return 8'h04;
         8'he3: return 8'h08;
         8'he5: return 8'h20;
         8'he7: return 8'h80;
         default: return 8'h00;
      endcase
   endfunction

   // Places a usage into the first free slot; a repeat counts as placed.
   function automatic bit place_key(ref logic [5:0][7:0] keys, input logic [7:0] u);
      int free_at;
      free_at = -1;
      if (u <= 8'h03) return 0;
      for (int i = 0; i < pkhr_pkg::KEY_SLOTS; i++) begin
         if (keys[i] == u) return 1;
         if (keys[i] == 8'h00 && free_at < 0) free_at = i;
      end
      if (free_at < 0) return 0;
      keys[free_at] = u;
      return 1;
   endfunction

   function automatic bit place_mod(ref logic [7:0] mods, input logic [7:0] b);
      if ((mods & b) != 0) return 0;
      mods = mods | b;
      return 1;
   endfunction

   function automatic bit feed_code_a(ref logic [5:0][7:0] keys, ref logic [7:0] mods,
                                      input logic [7:0] code);
      logic [7:0] b;
      if (code < 8'h03 || code >= 8'h62) return 0;
      b = mod_of_code_a(code);
      if (b != 0) return place_mod(mods, b);
      return place_key(keys, code_a_to_usage(code));
   endfunction

   // Builds the report for one poll and advances the kept Caps Lock bit.
   function automatic report_type build_report(input poll_type p);
      report_type r;
      logic [15:0] codes[3];
      logic [7:0] scan[pkhr_pkg::KEY_SLOTS];
      logic [7:0] u;
      logic [7:0] b;
      int n;
      int sx;
      int sy;
      bit right, left, up, down, btn_a, btn_b, btn_x;
      r.mods = '0;
      r.keys = '0;
      r.changed = 0;
      codes = '{p.code_a, p.code_b, p.code_c};
      n = 0;
      case (p.kind)
         pkhr_pkg::SRC_KBD_A: begin
            for (int i = 0; i < 3; i++)
               if (feed_code_a(r.keys, r.mods, codes[i][7:0])) r.changed = 1;
         end
         pkhr_pkg::SRC_KBD_B: begin
            if (!p.kbd_flags[4]) begin
               if (p.kbd_flags[0]) r.changed = place_key(r.keys, 8'h4a);
               for (int i = 0; i < 3; i++) begin
                  u = row_b_usage(codes[i]);
                  if (u > 8'h03) begin
                     if (u == 8'h39) caps_model = ~caps_model;
                     b = mod_of_usage(u);
                     if (b != 0 ? place_mod(r.mods, b) : place_key(r.keys, u))
                        r.changed = 1;
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < pkhr_pkg::KEY_SLOTS; i++) scan[i] = 8'h00;
            if (p.kind == pkhr_pkg::SRC_PAD_A) begin
               sx = $signed(p.stick_x ^ 8'h80);
               sy = $signed(p.stick_y ^ 8'h80);
               right = p.pad_buttons[1]; left = p.pad_buttons[0];
               up = p.pad_buttons[3];    down = p.pad_buttons[2];
               btn_a = p.pad_buttons[8]; btn_b = p.pad_buttons[9];
               btn_x = p.pad_buttons[10];
            end else begin
               sx = $signed(p.stick_x);
               sy = $signed(p.stick_y);
               right = p.pad_buttons[8];  left = p.pad_buttons[9];
               up = p.pad_buttons[11];    down = p.pad_buttons[10];
               btn_a = p.pad_buttons[15]; btn_b = p.pad_buttons[14];
               btn_x = p.pad_buttons[13];
            end
            // Stick directions first, then the pad buttons; the list holds
            // at most one entry per slot.
            if (sx > 64 && n < pkhr_pkg::KEY_SLOTS)  scan[n++] = 8'h5f;
            if (sx < -64 && n < pkhr_pkg::KEY_SLOTS) scan[n++] = 8'h5c;
            if (sy > 64 && n < pkhr_pkg::KEY_SLOTS)  scan[n++] = 8'h5e;
            if (sy < -64 && n < pkhr_pkg::KEY_SLOTS) scan[n++] = 8'h5d;
            if (right && n < pkhr_pkg::KEY_SLOTS) scan[n++] = 8'h5f;
            if (left && n < pkhr_pkg::KEY_SLOTS)  scan[n++] = 8'h5c;
            if (up && n < pkhr_pkg::KEY_SLOTS)    scan[n++] = 8'h5e;
            if (down && n < pkhr_pkg::KEY_SLOTS)  scan[n++] = 8'h5d;
            if (n < pkhr_pkg::KEY_SLOTS) begin
               if (btn_a) scan[n++] = 8'h61;
               else if (btn_b && n < pkhr_pkg::KEY_SLOTS) scan[n++] = 8'h4c;
               if (btn_x && n < pkhr_pkg::KEY_SLOTS) scan[n++] = 8'h22;
            end
            for (int i = 0; i < pkhr_pkg::KEY_SLOTS; i++)
               if (feed_code_a(r.keys, r.mods, scan[i])) r.changed = 1;
         end
      endcase
      r.clear_last = !r.changed && r.keys[0] == 8'h00;
      r.caps = caps_model;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s got %02h expected %02h", $time, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents the oldest pending poll; predicts on acceptance.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      poll_type p;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(build_report(pending_polls.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_polls.size() > 0 && (quiet_send || $urandom_range(99) >= 10)) begin
               p = pending_polls[0];
               req_tvalid <= 1'b1;
               req_tuser  <= p.kind;
               req_tdata  <= {p.stick_y, p.stick_x, p.pad_buttons, p.kbd_flags,
                              p.code_c, p.code_b, p.code_a};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks every accepted report against the oldest prediction
   // and decides the receiver stall.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      report_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $display("unexpected report at %0t", $time);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tdata[7:0] !== want.mods)
                  report_mismatch("modifiers", rsp_tdata[7:0], want.mods);
               for (int i = 0; i < 6; i++)
                  if (rsp_tdata[8+8*i +: 8] !== want.keys[i])
                     report_mismatch($sformatf("key_slot_%0d", i),
                                     rsp_tdata[8+8*i +: 8], want.keys[i]);
               if (rsp_tdata[56] !== want.changed)
                  report_mismatch("report_changed", rsp_tdata[56], want.changed);
               if (rsp_tdata[57] !== want.clear_last)
                  report_mismatch("clear_last", rsp_tdata[57], want.clear_last);
               if (rsp_tdata[58] !== want.caps)
                  report_mismatch("caps_led", rsp_tdata[58], want.caps);
               if (rsp_tdata[63:59] !== 5'b0)
                  report_mismatch("zero fill", rsp_tdata[63:59], 8'h00);
            end
         end
         if (hold_on) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_recv || $urandom_range(99) >= 10;
         end
      end
   end

   // Long receiver hold-off, counted in cycles once started.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (200) @(posedge clock);
      hold_on <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   function automatic poll_type blank_poll(input pkhr_pkg::src_type k);
      poll_type p;
      p.kind = k;
      p.code_a = '0; p.code_b = '0; p.code_c = '0;
      p.kbd_flags = '0; p.pad_buttons = '0;
      p.stick_x = 8'h80; p.stick_y = 8'h80;
      if (k == pkhr_pkg::SRC_PAD_B) begin
         p.stick_x = 8'h00;
         p.stick_y = 8'h00;
      end
      return p;
   endfunction

   function automatic poll_type keyboard_poll(input pkhr_pkg::src_type k,
                                              input logic [15:0] a,
                                              input logic [15:0] b, input logic [15:0] c,
                                              input logic [7:0] flags);
      poll_type p;
      p = blank_poll(k);
      p.code_a = a; p.code_b = b; p.code_c = c; p.kbd_flags = flags;
      return p;
   endfunction

   function automatic poll_type pad_poll(input pkhr_pkg::src_type k, input logic [15:0] btn,
                                         input logic [7:0] x, input logic [7:0] y);
      poll_type p;
      p = blank_poll(k);
      p.pad_buttons = btn; p.stick_x = x; p.stick_y = y;
      return p;
   endfunction

   // A row B scancode within the table's row and column range, though not every one maps:
   // row in the low byte, column plus two in the high byte.
   function automatic logic [15:0] valid_b_code();
      return {8'($urandom_range(17, 2)), 8'($urandom_range(8, 1))};
   endfunction

   function automatic poll_type random_poll();
      poll_type p;
      int mode;
      mode = $urandom_range(99);
      p.kind = pkhr_pkg::src_type'($urandom_range(3));
      p.code_a = 16'($urandom); p.code_b = 16'($urandom); p.code_c = 16'($urandom);
      p.kbd_flags = 8'($urandom); p.pad_buttons = 16'($urandom);
      p.stick_x = 8'($urandom); p.stick_y = 8'($urandom);
      if (mode < 70) begin
         // Well-formed content: codes mostly within the mapped ranges, errors rare.
         case (p.kind)
            pkhr_pkg::SRC_KBD_A: begin
               p.code_a[7:0] = 8'($urandom_range(8'h61, 0));
               p.code_b[7:0] = 8'($urandom_range(8'h61, 0));
               p.code_c[7:0] = 8'($urandom_range(8'h61, 0));
            end
            pkhr_pkg::SRC_KBD_B: begin
               p.code_a = valid_b_code();
               p.code_b = $urandom_range(3) == 0 ? 16'h0 : valid_b_code();
               p.code_c = $urandom_range(3) == 0 ? 16'h0f05 : valid_b_code();
               if ($urandom_range(9) != 0) p.kbd_flags[4] = 1'b0;
            end
            default: ;
         endcase
      end
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      int wait_cycles;
      caps_model = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed polls: field extremes, every source, each corner case.
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_A, 16'h0000, 16'h0000,
                                            16'h0000, 8'h00));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_A, 16'hff56, 16'hff54,
                                            16'hff5a, 8'hff));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_A, 16'h0010, 16'h0010,
                                            16'h0062, 8'h00));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_A, 16'h0003, 16'h0061,
                                            16'h00ff, 8'h00));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_A, 16'h0006, 16'h0035,
                                            16'h0040, 8'h00));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_B, 16'h0f05, 16'h0f05,
                                            16'h0000, 8'h00));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_B, 16'h0f05, 16'h1101,
                                            16'h0e01, 8'h10));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_B, 16'hffff, 16'h0009,
                                            16'h0100, 8'h01));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_B, 16'h1107, 16'h1002,
                                            16'h0e06, 8'hef));
      pending_polls.push_back(keyboard_poll(pkhr_pkg::SRC_KBD_B, 16'h0d05, 16'h0202,
                                            16'h0501, 8'h01));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_A, 16'h0000, 8'h80, 8'h80));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_A, 16'hffff, 8'hff, 8'h00));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_A, 16'h0700, 8'hc1, 8'h3f));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_A, 16'h0203, 8'hc0, 8'h40));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_B, 16'hffff, 8'h7f, 8'h80));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_B, 16'h6300, 8'h41, 8'hbf));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_B, 16'ha000, 8'h40, 8'hc0));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_B, 16'h00ff, 8'h00, 8'h00));
      pending_polls.push_back(pad_poll(pkhr_pkg::SRC_PAD_B, 16'h4f00, 8'h7f, 8'h7f));

      // Random polls, with one idle-free stretch and one long receiver stall
      // while the sender keeps offering words.
      for (int i = 0; i < 2000; i++) begin
         pending_polls.push_back(random_poll());
         if (i == 400) begin
            while (pending_polls.size() > 0) @(posedge clock);
            quiet_send = 1;
            quiet_recv = 1;
         end
         if (i == 700) begin
            while (pending_polls.size() > 0) @(posedge clock);
            quiet_send = 0;
            quiet_recv = 0;
         end
         if (i == 1000) begin
            while (pending_polls.size() > 0) @(posedge clock);
            quiet_send = 1;
            hold_go = 1;
         end
         if (i == 1100) begin
            while (pending_polls.size() > 0) @(posedge clock);
            quiet_send = 0;
         end
      end

      while (pending_polls.size() > 0 || req_tvalid) @(posedge clock);
      stim_done = 1;
      wait_cycles = 0;
      while (expected_reports.size() > 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (expected_reports.size() != 0)
            $display("%0d reports never arrived", expected_reports.size());
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5ms;
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
